>>> src/feistel_gf_multiply_cipher_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Feistel GF-multiply cipher unit
// Same-cycle-implication and next-cycle-implication forms; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef FEISTEL_GF_MULTIPLY_CIPHER_UNIT_DEFINES_SVH
`define FEISTEL_GF_MULTIPLY_CIPHER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define FGMC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fgmc: same-cycle check failed");
// next-cycle implication
`define FGMC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fgmc: next-cycle check failed");
`else
`define FGMC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FGMC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> src/fgmc_pkg.sv
// ----------------------------------------------------------------------------
// fgmc_pkg
// Types, constants and GF(2) helpers shared by the cipher unit.
// ----------------------------------------------------------------------------
package fgmc_pkg;

	localparam int MAX_ROUNDS = 8;
	localparam int RIDX_W     = 3;          // bits to name a round
	localparam int NR_W       = 4;          // bits to hold a round count
	localparam int HALF_W     = 8;
	localparam int KEYS_W     = MAX_ROUNDS * HALF_W;
	localparam int CIDX_W     = 2;

	localparam logic [NR_W-1:0] MAX_ROUNDS_N = NR_W'(MAX_ROUNDS);

	// reduction polynomials
	localparam logic [4:0] MOD_NARROW = 5'h13;
	localparam logic [8:0] MOD_WIDE   = 9'h11B;

	// configuration register indices
	localparam logic [CIDX_W-1:0] REG_ROUND_KEYS = 2'd0;
	localparam logic [CIDX_W-1:0] REG_NUM_ROUNDS = 2'd1;
	localparam logic [CIDX_W-1:0] REG_BLOCK_MODE = 2'd2;

	typedef struct packed {
		logic [KEYS_W-1:0] round_keys;
		logic [NR_W-1:0]   n_rounds;   // already saturated
		logic              wide;       // 8-bit halves
	} cfg_t;

	typedef struct packed {
		logic              dec;
		logic              wide;
		logic [HALF_W-1:0] left;
		logic [HALF_W-1:0] right;
	} blk_t;

	// round count as stored: values above the maximum saturate
	function automatic logic [NR_W-1:0] sat_rounds(logic [NR_W-1:0] n);
		return (n > MAX_ROUNDS_N) ? MAX_ROUNDS_N : n;
	endfunction

	// carry-less product of two bytes
	function automatic logic [14:0] clmul8(logic [7:0] a, logic [7:0] b);
		logic [14:0] p;
		p = '0;
		for (int k = 0; k < 8; k++) begin
			if (b[k])
				p = p ^ (15'(a) << k);
		end
		return p;
	endfunction

	// reduce a product modulo 0x11B (wide) or 0x13 (narrow half in low nibble)
	function automatic logic [7:0] gf_reduce(logic [14:0] p, logic wide);
		logic [14:0] w;
		logic [10:0] nw;
		w  = p;
		nw = p[10:0];
		for (int b = 14; b >= 8; b--) begin
			if (w[b])
				w = w ^ (15'(MOD_WIDE) << (b - 8));
		end
		for (int b = 10; b >= 4; b--) begin
			if (nw[b])
				nw = nw ^ (11'(MOD_NARROW) << (b - 4));
		end
		return wide ? w[7:0] : {4'b0000, nw[3:0]};
	endfunction

endpackage

>>> src/fgmc_ifs.sv
// ----------------------------------------------------------------------------
// fgmc channel interfaces
// Request, result and configuration-write channels with valid/ready.
// ----------------------------------------------------------------------------
interface fgmc_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] left_half;
	logic [7:0] right_half;

	modport source (output valid, req_type, left_half, right_half, input ready);
	modport sink   (input valid, req_type, left_half, right_half, output ready);
endinterface

interface fgmc_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_first;
	logic [7:0] out_second;

	modport source (output valid, out_first, out_second, input ready);
	modport sink   (input valid, out_first, out_second, output ready);
endinterface

interface fgmc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [63:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> src/fgmc_round.sv
// ----------------------------------------------------------------------------
// fgmc_round
// One Feistel round as one pipeline stage, with its own valid bit and
// ready chaining so a held stage lets bubbles upstream fill in.
// ----------------------------------------------------------------------------
module fgmc_round (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fgmc_pkg::cfg_t                cfg,
	input  logic [fgmc_pkg::RIDX_W-1:0]   round_idx,
	input  logic                          up_valid,
	output logic                          up_ready,
	input  fgmc_pkg::blk_t                up_blk,
	output logic                          dn_valid,
	input  logic                          dn_ready,
	output fgmc_pkg::blk_t                dn_blk
);
	import fgmc_pkg::*;

	logic                valid_q;
	blk_t                blk_q;
	blk_t                blk_nxt;
	logic                active;
	logic [RIDX_W-1:0]   key_idx;
	logic [HALF_W-1:0]   key;
	logic [HALF_W-1:0]   f;

	// round applies only below the configured count
	assign active = {1'b0, round_idx} < cfg.n_rounds;

	// decryption walks the key schedule backwards
	assign key_idx = up_blk.dec ? RIDX_W'(cfg.n_rounds - NR_W'(1) - {1'b0, round_idx})
	                            : round_idx;
	assign key     = cfg.round_keys[key_idx*HALF_W +: HALF_W];

	// round function: carry-less multiply then field reduction
	assign f = gf_reduce(clmul8(up_blk.right, key), up_blk.wide);

	always_comb begin
		blk_nxt = up_blk;
		if (active) begin
			blk_nxt.left  = up_blk.right;
			blk_nxt.right = up_blk.left ^ f;
		end
	end

	assign up_ready = !valid_q || dn_ready;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			blk_q <= blk_nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_blk   = blk_q;

endmodule

>>> src/feistel_gf_multiply_cipher_unit.sv
// ----------------------------------------------------------------------------
// feistel_gf_multiply_cipher_unit
// Feistel cipher with a GF(2^4)/GF(2^8) multiply round function, one
// pipeline stage per round.
//
//   channel  dir  payload                               word accepted on
//   req      in   req_type, left_half, right_half       valid && ready
//   res      out  out_first, out_second                 valid && ready
//   cfg      in   index (0 keys, 1 rounds, 2 mode), data valid && ready
//
// A word passes through every round stage on its way from request to result;
// stages beyond the round count pass the halves through unchanged.
// One word enters per cycle while the first stage can take it. The last round register is the result register.
// A held result stalls only the stages behind it that are full.
// Reset clears all stage valid bits and the configuration to zero.
// The configuration port is always ready.
// ----------------------------------------------------------------------------
`include "feistel_gf_multiply_cipher_unit_defines.svh"

module feistel_gf_multiply_cipher_unit (
	input logic        clk,
	input logic        arst_n,
	fgmc_req_if.sink   req,
	fgmc_res_if.source res,
	fgmc_cfg_if.sink   cfg
);
	import fgmc_pkg::*;

	cfg_t cfg_q;
	logic stg_valid [0:MAX_ROUNDS];
	logic stg_ready [0:MAX_ROUNDS];
	blk_t stg_blk   [0:MAX_ROUNDS];

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_ROUND_KEYS: cfg_q.round_keys <= cfg.data;
				REG_NUM_ROUNDS: cfg_q.n_rounds   <= sat_rounds(cfg.data[NR_W-1:0]);
				REG_BLOCK_MODE: cfg_q.wide       <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// entry: mask halves to the mode width
	always_comb begin
		stg_valid[0]      = req.valid;
		stg_blk[0].dec    = req.req_type;
		stg_blk[0].wide   = cfg_q.wide;
		stg_blk[0].left   = cfg_q.wide ? req.left_half  : {4'b0000, req.left_half[3:0]};
		stg_blk[0].right  = cfg_q.wide ? req.right_half : {4'b0000, req.right_half[3:0]};
	end
	assign req.ready = stg_ready[0];

	// round stages
	for (genvar g = 0; g < MAX_ROUNDS; g++) begin : g_round
		fgmc_round u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.cfg       (cfg_q),
			.round_idx (RIDX_W'(g)),
			.up_valid  (stg_valid[g]),
			.up_ready  (stg_ready[g]),
			.up_blk    (stg_blk[g]),
			.dn_valid  (stg_valid[g+1]),
			.dn_ready  (stg_ready[g+1]),
			.dn_blk    (stg_blk[g+1])
		);
	end

	// result: final right half first, then left
	assign res.valid             = stg_valid[MAX_ROUNDS];
	assign res.out_first         = stg_blk[MAX_ROUNDS].right;
	assign res.out_second        = stg_blk[MAX_ROUNDS].left;
	assign stg_ready[MAX_ROUNDS] = res.ready;

	// narrow-mode words never carry upper nibbles
	`FGMC_ASSERT_IMP(a_narrow_upper_zero, clk, arst_n, res.valid && !stg_blk[MAX_ROUNDS].wide, res.out_first[7:4] == 4'b0000 && res.out_second[7:4] == 4'b0000)
	// input only back-pressured when the first stage is occupied
	`FGMC_ASSERT_IMP(a_req_stall_full, clk, arst_n, !req.ready, stg_valid[1])
	// round count write is stored saturated
	`FGMC_ASSERT_NXT(a_rounds_sat, clk, arst_n, cfg.valid && cfg.ready && cfg.index == REG_NUM_ROUNDS, cfg_q.n_rounds == sat_rounds($past(cfg.data[NR_W-1:0])))

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Feistel GF-multiply cipher unit testbench
// Drives request words through a directed table and then random phases under
// several key, round-count and half-width settings. Every result word is checked
// against the row's expected word or a predictor of the Feistel network kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import fgmc_pkg::*;

	// request direction and half width
	localparam logic OP_ENCRYPT  = 1'b0;
	localparam logic OP_DECRYPT  = 1'b1;
	localparam logic MODE_NARROW = 1'b0;
	localparam logic MODE_WIDE   = 1'b1;

	// index with no register behind it
	localparam logic [CIDX_W-1:0] REG_UNUSED = 2'd3;

	localparam int SETTLE_CYCLES = 12;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int NUM_PHASES = 9;
	localparam int WORDS_PER_PHASE = 170;

	typedef struct packed {
		logic [7:0] first;
		logic [7:0] second;
	} cipher_out_t;

	typedef struct packed {
		logic [63:0] keys;
		logic [3:0]  rounds;
		logic        wide;
		logic        poke;         // also write the unused index
		logic        op;
		logic [7:0]  left;
		logic [7:0]  right;
		logic        typed;        // expected word given in the row
		logic [7:0]  want_first;
		logic [7:0]  want_second;
	} vector_t;

	localparam vector_t DIRECTED [20] = '{
		// after reset: no rounds, narrow halves
		'{64'h0, 4'd0, MODE_NARROW, 1'b0, OP_ENCRYPT, 8'hFF, 8'hAB, 1'b1, 8'h0B, 8'h0F},
		'{64'h0, 4'd0, MODE_NARROW, 1'b0, OP_DECRYPT, 8'h00, 8'h00, 1'b1, 8'h00, 8'h00},
		'{64'h0, 4'd0, MODE_NARROW, 1'b0, OP_ENCRYPT, 8'hF0, 8'h5F, 1'b1, 8'h0F, 8'h00},
		// wide halves pass through untouched
		'{64'h0, 4'd0, MODE_WIDE, 1'b0, OP_ENCRYPT, 8'hFF, 8'h80, 1'b1, 8'h80, 8'hFF},
		// zero key: a round only swaps
		'{64'h0, 4'd1, MODE_WIDE, 1'b0, OP_ENCRYPT, 8'h5A, 8'hC3, 1'b1, 8'h5A, 8'hC3},
		// unit key: product below the field degree used as is
		'{64'h1, 4'd1, MODE_WIDE, 1'b1, OP_ENCRYPT, 8'h12, 8'h34, 1'b1, 8'h26, 8'h34},
		'{64'h1, 4'd1, MODE_WIDE, 1'b0, OP_DECRYPT, 8'hFF, 8'hFF, 1'b1, 8'h00, 8'hFF},
		// narrow reduction, upper nibbles ignored
		'{64'h2, 4'd1, MODE_NARROW, 1'b0, OP_ENCRYPT, 8'h00, 8'h0F, 1'b0, 8'h00, 8'h00},
		'{64'h2, 4'd1, MODE_NARROW, 1'b0, OP_DECRYPT, 8'hF3, 8'hFE, 1'b0, 8'h00, 8'h00},
		// round count above the maximum saturates
		'{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, MODE_WIDE, 1'b0, OP_ENCRYPT, 8'hFF, 8'hFF, 1'b0,
			8'h00, 8'h00},
		'{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, MODE_WIDE, 1'b0, OP_DECRYPT, 8'h00, 8'h01, 1'b0,
			8'h00, 8'h00},
		// full key schedule both ways, both widths
		'{64'h0123_4567_89AB_CDEF, 4'd8, MODE_WIDE, 1'b0, OP_ENCRYPT, 8'h3C, 8'hA5, 1'b0,
			8'h00, 8'h00},
		'{64'h0123_4567_89AB_CDEF, 4'd8, MODE_WIDE, 1'b0, OP_DECRYPT, 8'h3C, 8'hA5, 1'b0,
			8'h00, 8'h00},
		'{64'h0123_4567_89AB_CDEF, 4'd8, MODE_NARROW, 1'b0, OP_ENCRYPT, 8'hAB, 8'hCD, 1'b0,
			8'h00, 8'h00},
		'{64'h0123_4567_89AB_CDEF, 4'd8, MODE_NARROW, 1'b0, OP_DECRYPT, 8'h7F, 8'h80, 1'b0,
			8'h00, 8'h00},
		'{64'hFEDC_BA98_7654_3210, 4'd3, MODE_WIDE, 1'b0, OP_ENCRYPT, 8'h00, 8'hFF, 1'b0,
			8'h00, 8'h00},
		'{64'hFEDC_BA98_7654_3210, 4'd3, MODE_WIDE, 1'b0, OP_DECRYPT, 8'hFF, 8'h00, 1'b0,
			8'h00, 8'h00},
		// top key bit set in every round: deepest reduction
		'{64'h8080_8080_8080_8080, 4'd8, MODE_WIDE, 1'b0, OP_ENCRYPT, 8'h80, 8'h80, 1'b0,
			8'h00, 8'h00},
		// saturated to eight swaps with a zero key: halves come back in place
		'{64'h0, 4'd15, MODE_NARROW, 1'b0, OP_ENCRYPT, 8'h09, 8'h06, 1'b1, 8'h06, 8'h09},
		'{64'h0, 4'd0, MODE_NARROW, 1'b1, OP_DECRYPT, 8'hFF, 8'hFF, 1'b1, 8'h0F, 8'h0F}
	};

	// per-phase round counts and widths for the random part
	localparam logic [3:0] PHASE_ROUNDS [NUM_PHASES] = '{
		4'd8, 4'd0, 4'd15, 4'd1, 4'd8, 4'd3, 4'd8, 4'd9, 4'd5
	};
	localparam logic [NUM_PHASES-1:0] PHASE_WIDE = 9'b1_0110_0101;

	logic clk;
	logic arst_n;

	fgmc_req_if req_ch();
	fgmc_res_if res_ch();
	fgmc_cfg_if cfg_ch();

	feistel_gf_multiply_cipher_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// bench copy of the configuration
	logic [63:0] key_sched;
	logic [3:0]  round_cnt;
	logic        wide_mode;

	cipher_out_t expected_words [$];
	int          bad_words;
	int          src_idle_pct;
	int          snk_idle_pct;
	int          hold_requests;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// round function: carry-less product reduced in GF(2^4) or GF(2^8)
	function automatic logic [7:0] gf_round_f(logic [7:0] half, logic [7:0] key, logic wide);
		logic [15:0] prod;
		logic [8:0]  poly;
		int          deg;
		prod = '0;
		for (int k = 0; k < 8; k++) begin
			if (key[k])
				prod = prod ^ ({8'h00, half} << k);
		end
		deg  = wide ? 8 : 4;
		poly = wide ? MOD_WIDE : {4'b0000, MOD_NARROW};
		for (int b = 15; b >= deg; b--) begin
			if (prod[b])
				prod = prod ^ (16'(poly) << (b - deg));
		end
		return wide ? prod[7:0] : {4'b0000, prod[3:0]};
	endfunction

	// whole Feistel network under the current configuration
	function automatic cipher_out_t feistel_predict(logic op, logic [7:0] left_in,
			logic [7:0] right_in);
		logic [7:0]  mask;
		logic [7:0]  l;
		logic [7:0]  r;
		logic [7:0]  nr;
		int          n;
		int          idx;
		cipher_out_t word;
		mask = wide_mode ? 8'hFF : 8'h0F;
		l    = left_in & mask;
		r    = right_in & mask;
		n    = (round_cnt > 4'd8) ? 8 : int'(round_cnt);
		for (int i = 0; i < n; i++) begin
			idx = (op == OP_DECRYPT) ? (n - 1 - i) : i;
			nr  = (l ^ (gf_round_f(r, key_sched[idx*8 +: 8], wide_mode) & mask)) & mask;
			l   = r;
			r   = nr;
		end
		word.first  = r;
		word.second = l;
		return word;
	endfunction

	function automatic void apply_reg(logic [CIDX_W-1:0] idx, logic [63:0] val);
		case (idx)
			REG_ROUND_KEYS: key_sched = val;
			REG_NUM_ROUNDS: round_cnt = val[3:0];
			REG_BLOCK_MODE: wide_mode = val[0];
			default: ;
		endcase
	endfunction

	// result side: ready pattern, with a long hold-off on request
	always @(negedge clk) begin
		int hold_left;
		int hold_seen;
		if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = RX_HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		cipher_out_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_words.size() == 0) begin
				$error("result word with none expected: first %h second %h",
					res_ch.out_first, res_ch.out_second);
				bad_words = bad_words + 1;
			end else begin
				want = expected_words.pop_front();
				if (res_ch.out_first !== want.first) begin
					$error("out_first: expected %h, got %h", want.first, res_ch.out_first);
					bad_words = bad_words + 1;
				end
				if (res_ch.out_second !== want.second) begin
					$error("out_second: expected %h, got %h", want.second, res_ch.out_second);
					bad_words = bad_words + 1;
				end
			end
		end
	end

	// offer one request word; called and returns at a falling edge
	task automatic send_block(logic op, logic [7:0] l, logic [7:0] r, logic typed,
			cipher_out_t want);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= op;
		req_ch.left_half  <= l;
		req_ch.right_half <= r;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		expected_words.insert(expected_words.size(),
			typed ? want : feistel_predict(op, l, r));
		@(negedge clk);
	endtask

	// stop requests and wait for the pipeline to empty
	task automatic settle_pipeline();
		req_ch.valid <= 1'b0;
		while (expected_words.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// one register write; valid is left high for a following write
	task automatic write_reg(logic [CIDX_W-1:0] idx, logic [63:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		apply_reg(idx, val);
		@(negedge clk);
	endtask

	// write all registers; unused upper data bits carry noise
	task automatic load_config(logic [63:0] keys, logic [3:0] rounds, logic wide, logic poke);
		write_reg(REG_ROUND_KEYS, keys);
		write_reg(REG_NUM_ROUNDS, {$urandom, 28'($urandom_range(268435455)), rounds});
		write_reg(REG_BLOCK_MODE, {$urandom, 31'($urandom_range(2147483647)), wide});
		if (poke)
			write_reg(REG_UNUSED, {$urandom, $urandom});
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		cipher_out_t typed_word;
		logic [63:0] keys;
		logic        op;
		logic [7:0]  l;
		logic [7:0]  r;

		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.req_type   = OP_ENCRYPT;
		req_ch.left_half  = '0;
		req_ch.right_half = '0;
		res_ch.ready      = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = REG_ROUND_KEYS;
		cfg_ch.data       = '0;
		bad_words         = 0;
		hold_requests     = 0;
		src_idle_pct      = 10;
		snk_idle_pct      = 62;
		key_sched         = '0;
		round_cnt         = '0;
		wide_mode         = MODE_NARROW;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed table
		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].keys != key_sched || DIRECTED[i].rounds != round_cnt ||
					DIRECTED[i].wide != wide_mode || DIRECTED[i].poke) begin
				settle_pipeline();
				load_config(DIRECTED[i].keys, DIRECTED[i].rounds, DIRECTED[i].wide,
					DIRECTED[i].poke);
			end
			typed_word.first  = DIRECTED[i].want_first;
			typed_word.second = DIRECTED[i].want_second;
			send_block(DIRECTED[i].op, DIRECTED[i].left, DIRECTED[i].right,
				DIRECTED[i].typed, typed_word);
		end

		// random phases, one configuration each
		typed_word = '0;
		for (int p = 0; p < NUM_PHASES; p++) begin
			settle_pipeline();
			if (p < 3) begin
				src_idle_pct = 10;
				snk_idle_pct = 62;
			end else if (p < 6) begin
				src_idle_pct = 62;
				snk_idle_pct = 10;
			end else begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			keys = (p == 2) ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom};
			load_config(keys, PHASE_ROUNDS[p], PHASE_WIDE[p], (p % 3) == 0);
			// receiver stalls for a long stretch while words keep coming
			if (p == 6)
				hold_requests = hold_requests + 1;
			for (int w = 0; w < WORDS_PER_PHASE; w++) begin
				op = $urandom_range(1) ? OP_DECRYPT : OP_ENCRYPT;
				l  = 8'($urandom);
				r  = 8'($urandom);
				if ($urandom_range(9) == 0)
					l = $urandom_range(1) ? 8'hFF : 8'h00;
				if ($urandom_range(9) == 0)
					r = $urandom_range(1) ? 8'hFF : 8'h00;
				send_block(op, l, r, 1'b0, typed_word);
			end
		end

		settle_pipeline();
		if (bad_words == 0)
			$display("feistel_gf_multiply_cipher_unit test passed");
		else
			$display("feistel_gf_multiply_cipher_unit test failed");
		$finish;
	end

	// overall time limit
	initial begin
		#2000000;
		$display("feistel_gf_multiply_cipher_unit test failed");
		$finish;
	end

endmodule
